[sv/biq_pkg.sv]
// Shared types and constants for the biquad IIR section.
// No dependencies; imported by every module of the block.
package biq_pkg;

	// Width of each delay word (sample units, fraction bits included)
	localparam int STATE_W   = 60;
	localparam int NUM_COEFS = 5;
	localparam int CFG_IDX_W = 3;

	// Coefficient register indexes, in configuration order
	typedef enum logic [CFG_IDX_W-1:0] {
		COEF_B0 = 3'd0,
		COEF_B1 = 3'd1,
		COEF_B2 = 3'd2,
		COEF_A1 = 3'd3,
		COEF_A2 = 3'd4
	} coef_idx_t;

	// Second multiplier operand
	typedef enum logic [1:0] {
		SRC_X_IN = 2'd0,
		SRC_X_Q  = 2'd1,
		SRC_Y_Q  = 2'd2
	} mul_src_t;

	// Accumulator operation
	typedef enum logic [2:0] {
		ACC_HOLD    = 3'd0,
		ACC_LOAD_D1 = 3'd1,
		ACC_ADD     = 3'd2,
		ACC_SUB     = 3'd3,
		ACC_LOAD_D2 = 3'd4,
		ACC_LOAD_P  = 3'd5
	} acc_op_t;

	// Sequencer to datapath control
	typedef struct packed {
		coef_idx_t mul_coef;
		mul_src_t  mul_src;
		acc_op_t   acc_op;
		logic      start;
		logic      y_load;
		logic      d1_load;
		logic      fin_load;
	} mac_ctrl_t;

endpackage

[sv/biq_if.sv]
// Item channel interfaces for the biquad section (valid/ready handshake).
// No dependencies.
interface biq_in_if #(parameter int SAMPLE_WIDTH = 24);
	logic                           valid;
	logic                           ready;
	logic signed [SAMPLE_WIDTH-1:0] sample_in;
	logic                           restart;

	modport source (output valid, output sample_in, output restart, input ready);
	modport sink   (input valid, input sample_in, input restart, output ready);
endinterface

interface biq_out_if #(parameter int SAMPLE_WIDTH = 24);
	logic                           valid;
	logic                           ready;
	logic signed [SAMPLE_WIDTH-1:0] sample_out;
	logic                           clipped;

	modport source (output valid, output sample_out, output clipped, input ready);
	modport sink   (input valid, input sample_out, input clipped, output ready);
endinterface

[sv/biq_coef_regs.sv]
// Coefficient register file written through the plain configuration port.
// Depends on biq_pkg.
module biq_coef_regs import biq_pkg::*; #(
	parameter int COEF_WIDTH     = 32,
	parameter int COEF_FRAC_BITS = 28
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [CFG_IDX_W-1:0]         cfg_index,
	input  logic [COEF_WIDTH-1:0]        cfg_data,
	output logic signed [COEF_WIDTH-1:0] coef_q [NUM_COEFS]
);

	// b0 resets to 1.0
	localparam logic [COEF_WIDTH-1:0] ONE = {{(COEF_WIDTH-1){1'b0}}, 1'b1} << COEF_FRAC_BITS;

	// Register writes; indexes beyond the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q[COEF_B0] <= ONE;
			coef_q[COEF_B1] <= '0;
			coef_q[COEF_B2] <= '0;
			coef_q[COEF_A1] <= '0;
			coef_q[COEF_A2] <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				COEF_B0: coef_q[COEF_B0] <= cfg_data;
				COEF_B1: coef_q[COEF_B1] <= cfg_data;
				COEF_B2: coef_q[COEF_B2] <= cfg_data;
				COEF_A1: coef_q[COEF_A1] <= cfg_data;
				COEF_A2: coef_q[COEF_A2] <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

[sv/biq_mac.sv]
// Shared multiply-accumulate datapath: one multiplier, one accumulator,
// delay words, rounding/saturation and the output register. Depends on biq_pkg.
module biq_mac import biq_pkg::*; #(
	parameter int SAMPLE_WIDTH   = 24,
	parameter int COEF_WIDTH     = 32,
	parameter int COEF_FRAC_BITS = 28
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  mac_ctrl_t                      ctrl,
	input  logic signed [SAMPLE_WIDTH-1:0] sample_in,
	input  logic                           restart,
	input  logic signed [COEF_WIDTH-1:0]   coef [NUM_COEFS],
	output logic signed [SAMPLE_WIDTH-1:0] sample_out,
	output logic                           clipped
);

	localparam int PROD_W = SAMPLE_WIDTH + COEF_WIDTH;
	localparam int M1     = (PROD_W > STATE_W) ? PROD_W : STATE_W;
	localparam int M2     = (M1 > COEF_FRAC_BITS + SAMPLE_WIDTH) ? M1
	                        : COEF_FRAC_BITS + SAMPLE_WIDTH;
	localparam int ACC_W  = M2 + 2;

	localparam logic signed [ACC_W-1:0] HALF =
		{{(ACC_W-1){1'b0}}, 1'b1} << (COEF_FRAC_BITS - 1);
	localparam logic signed [SAMPLE_WIDTH-1:0] Y_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
	localparam logic signed [SAMPLE_WIDTH-1:0] Y_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
	localparam logic signed [STATE_W-1:0]      D_MAX = {1'b0, {(STATE_W-1){1'b1}}};
	localparam logic signed [STATE_W-1:0]      D_MIN = {1'b1, {(STATE_W-1){1'b0}}};

	logic signed [SAMPLE_WIDTH-1:0] x_q;
	logic signed [SAMPLE_WIDTH-1:0] y_q;
	logic                           clip_q;
	logic signed [STATE_W-1:0]      d1_q;
	logic signed [STATE_W-1:0]      d2_q;
	logic signed [PROD_W-1:0]       prod_q;
	logic signed [ACC_W-1:0]        acc_q;
	logic signed [SAMPLE_WIDTH-1:0] sample_out_q;
	logic                           clipped_q;

	logic signed [COEF_WIDTH-1:0]   mul_a;
	logic signed [SAMPLE_WIDTH-1:0] mul_b;
	logic signed [PROD_W-1:0]       mul_res;
	logic signed [ACC_W-1:0]        prod_ext;
	logic signed [ACC_W-1:0]        d1_eff;
	logic signed [ACC_W-1:0]        acc_shr;
	logic [ACC_W-SAMPLE_WIDTH:0]    y_top;
	logic                           y_fits;
	logic signed [SAMPLE_WIDTH-1:0] y_sat;
	logic [ACC_W-STATE_W:0]         d_top;
	logic                           d_fits;
	logic signed [STATE_W-1:0]      d_sat;

	// Operand selection for the shared multiplier
	always_comb begin
		case (ctrl.mul_coef)
			COEF_B0: mul_a = coef[COEF_B0];
			COEF_B1: mul_a = coef[COEF_B1];
			COEF_B2: mul_a = coef[COEF_B2];
			COEF_A1: mul_a = coef[COEF_A1];
			COEF_A2: mul_a = coef[COEF_A2];
			default: mul_a = '0;
		endcase
		case (ctrl.mul_src)
			SRC_X_IN: mul_b = sample_in;
			SRC_Y_Q:  mul_b = y_q;
			default:  mul_b = x_q;
		endcase
	end

	assign mul_res  = mul_a * mul_b;
	assign prod_ext = ACC_W'(prod_q);
	// Restart zeroes the first delay word as it is read
	assign d1_eff   = (ctrl.start && restart) ? '0 : ACC_W'(d1_q);

	// Round half up (offset already in acc), floor shift, saturate to sample range
	assign acc_shr = acc_q >>> COEF_FRAC_BITS;
	assign y_top   = acc_shr[ACC_W-1:SAMPLE_WIDTH-1];
	assign y_fits  = (&y_top) | ~(|y_top);
	assign y_sat   = y_fits ? acc_shr[SAMPLE_WIDTH-1:0] : (acc_shr[ACC_W-1] ? Y_MIN : Y_MAX);

	// Saturate accumulator to delay word range
	assign d_top  = acc_q[ACC_W-1:STATE_W-1];
	assign d_fits = (&d_top) | ~(|d_top);
	assign d_sat  = d_fits ? acc_q[STATE_W-1:0] : (acc_q[ACC_W-1] ? D_MIN : D_MAX);

	// Product, accumulator, input sample, result and output registers
	always_ff @(posedge clk) begin
		prod_q <= mul_res;
		case (ctrl.acc_op)
			ACC_LOAD_D1: acc_q <= d1_eff + HALF;
			ACC_ADD:     acc_q <= acc_q + prod_ext;
			ACC_SUB:     acc_q <= acc_q - prod_ext;
			ACC_LOAD_D2: acc_q <= ACC_W'(d2_q);
			ACC_LOAD_P:  acc_q <= prod_ext;
			default:     acc_q <= acc_q;
		endcase
		if (ctrl.start) begin
			x_q <= sample_in;
		end
		if (ctrl.y_load) begin
			y_q    <= y_sat;
			clip_q <= ~y_fits;
		end
		if (ctrl.fin_load) begin
			sample_out_q <= y_q;
			clipped_q    <= clip_q;
		end
	end

	// Delay words
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			d1_q <= '0;
			d2_q <= '0;
		end else begin
			if (ctrl.start && restart) begin
				d1_q <= '0;
				d2_q <= '0;
			end
			if (ctrl.d1_load) begin
				d1_q <= d_sat;
			end
			if (ctrl.fin_load) begin
				d2_q <= d_sat;
			end
		end
	end

	assign sample_out = sample_out_q;
	assign clipped    = clipped_q;

endmodule

[sv/biq_seq.sv]
// Sequencer that steps the shared MAC through one sample and owns the
// channel handshakes. Depends on biq_pkg.
module biq_seq import biq_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	output mac_ctrl_t ctrl
);

	typedef enum logic [7:0] {
		ST_IDLE  = 8'b0000_0001,
		ST_ADD   = 8'b0000_0010,
		ST_ROUND = 8'b0000_0100,
		ST_FB1   = 8'b0000_1000,
		ST_FF2   = 8'b0001_0000,
		ST_FB2   = 8'b0010_0000,
		ST_SUB   = 8'b0100_0000,
		ST_FIN   = 8'b1000_0000
	} state_t;

	state_t state_q;
	state_t state_nxt;
	logic   out_valid_q;
	logic   fin_ok;

	// Result may be written once the output register is empty or being drained
	assign fin_ok = !out_valid_q || out_ready;

	// Step decode
	always_comb begin
		state_nxt     = state_q;
		ctrl.mul_coef = COEF_B0;
		ctrl.mul_src  = SRC_X_Q;
		ctrl.acc_op   = ACC_HOLD;
		ctrl.start    = 1'b0;
		ctrl.y_load   = 1'b0;
		ctrl.d1_load  = 1'b0;
		ctrl.fin_load = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				// b0*x straight from the port; acc <- d1 + half
				if (in_valid) begin
					ctrl.start    = 1'b1;
					ctrl.mul_coef = COEF_B0;
					ctrl.mul_src  = SRC_X_IN;
					ctrl.acc_op   = ACC_LOAD_D1;
					state_nxt     = ST_ADD;
				end
			end
			ST_ADD: begin
				ctrl.acc_op = ACC_ADD;
				state_nxt   = ST_ROUND;
			end
			ST_ROUND: begin
				ctrl.y_load   = 1'b1;
				ctrl.mul_coef = COEF_B1;
				ctrl.acc_op   = ACC_LOAD_D2;
				state_nxt     = ST_FB1;
			end
			ST_FB1: begin
				// acc += b1*x while a1*y is formed
				ctrl.mul_coef = COEF_A1;
				ctrl.mul_src  = SRC_Y_Q;
				ctrl.acc_op   = ACC_ADD;
				state_nxt     = ST_FF2;
			end
			ST_FF2: begin
				ctrl.mul_coef = COEF_B2;
				ctrl.acc_op   = ACC_SUB;
				state_nxt     = ST_FB2;
			end
			ST_FB2: begin
				// first delay word done; restart acc with b2*x
				ctrl.mul_coef = COEF_A2;
				ctrl.mul_src  = SRC_Y_Q;
				ctrl.d1_load  = 1'b1;
				ctrl.acc_op   = ACC_LOAD_P;
				state_nxt     = ST_SUB;
			end
			ST_SUB: begin
				ctrl.acc_op = ACC_SUB;
				state_nxt   = ST_FIN;
			end
			ST_FIN: begin
				if (fin_ok) begin
					ctrl.fin_load = 1'b1;
					state_nxt     = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// State and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (ctrl.fin_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

endmodule

[sv/biquad_iir_filter_top.sv]
// Biquad IIR section, transposed direct form II, one shared multiplier.
// A new input item is accepted only in the idle state, once the previous item
// is finished, since the single multiplier forms the five products in sequence;
// a finished result waits in the output register.
// Reset: b0 = 1.0, other coefficients 0, both delay words 0, no item pending.
module biquad_iir_filter_top import biq_pkg::*; #(
	parameter int SAMPLE_WIDTH   = 24,
	parameter int COEF_WIDTH     = 32,
	parameter int COEF_FRAC_BITS = 28
) (
	input  logic                  clk,
	input  logic                  arst_n,
	biq_in_if.sink                in_chan,
	biq_out_if.source             out_chan,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [COEF_WIDTH-1:0] cfg_data
);

	logic signed [COEF_WIDTH-1:0] coef_q [NUM_COEFS];
	mac_ctrl_t                    ctrl;

	// Coefficient registers
	biq_coef_regs #(
		.COEF_WIDTH     (COEF_WIDTH),
		.COEF_FRAC_BITS (COEF_FRAC_BITS)
	) u_coef (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.coef_q    (coef_q)
	);

	// Step sequencer and handshakes
	biq_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_chan.valid),
		.in_ready  (in_chan.ready),
		.out_valid (out_chan.valid),
		.out_ready (out_chan.ready),
		.ctrl      (ctrl)
	);

	// Shared MAC datapath
	biq_mac #(
		.SAMPLE_WIDTH   (SAMPLE_WIDTH),
		.COEF_WIDTH     (COEF_WIDTH),
		.COEF_FRAC_BITS (COEF_FRAC_BITS)
	) u_mac (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl       (ctrl),
		.sample_in  (in_chan.sample_in),
		.restart    (in_chan.restart),
		.coef       (coef_q),
		.sample_out (out_chan.sample_out),
		.clipped    (out_chan.clipped)
	);

endmodule
